// ===== rtl/core/rolling_hash_string_matcher_unit_assert.svh =====
// Assertion macros shared by the rolling hash matcher RTL.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ROLLING_HASH_STRING_MATCHER_UNIT_ASSERT_SVH
`define ROLLING_HASH_STRING_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RHSM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RHSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rhsm_pkg.sv =====
// Package for the rolling hash string matcher: opcodes, status codes, mod-101 constants.
// No dependencies; imported by rhsm_mod101, the top level and the testbench.
package rhsm_pkg;

    localparam int MAX_PATTERN_DEF   = 64;
    localparam int POSITION_BITS_DEF = 16;

    localparam int                     TEXT_COUNT_W   = 17;
    localparam logic [TEXT_COUNT_W-1:0] TEXT_COUNT_MAX = 17'h1FFFF;

    localparam int            HASH_W    = 7;
    localparam logic [6:0]    MODULUS   = 7'd101;
    localparam logic [6:0]    LEAD_ONE  = 7'd1;
    // 256 mod 101
    localparam logic [5:0]    RADIX_MOD = 6'd54;

    // Reducer operand is below 2^15 (largest is 255 * 100).
    // q = (x * RECIP) >> RECIP_SHIFT is exact for that range.
    localparam int             RED_W       = 15;
    localparam int             RECIP_W     = 16;
    localparam logic [15:0]    RECIP       = 16'd41528;
    localparam int             RECIP_SHIFT = 22;
    localparam int             QUOT_W      = 9;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_TEXT    = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_NO_MATCH   = 2'd0,
        ST_FOUND      = 2'd1,
        ST_FALSE_HIT  = 2'd2,
        ST_SHORT_TEXT = 2'd3
    } status_t;

endpackage

// ===== rtl/core/rolling_hash_string_matcher_unit.sv =====
// Top level of the Rabin-Karp (radix 256, mod 101) string matcher.
// Depends on rhsm_pkg, rhsm_ram, rhsm_mod101 and the assertion macro header.
//
// Usage:
//   Item channel (item_valid / item_stall): opcode, char_byte, end_of_text.
//   A transaction moves when item_valid is high and item_stall is low.
//   Load the pattern with pattern-byte opcodes, then stream text bytes.
//   Result channel (result_valid / result_stall): status, position, window_hash.
//   At most one result per text byte; pattern, clear and restart give none.
// Work per transaction is set by the shared mod-101 reducer (one pass while
//   filling, two per rolling update), the ring read ahead of it, and the
//   byte-serial compare walk through both RAMs. Clear, restart and a dropped
//   pattern byte need no reducer pass; a pattern byte needs a hash pass and,
//   after the first byte, a power pass. A text byte with an empty pattern needs
//   none; a hash hit adds a read step and a check step per compared byte.
//   The result register is loaded in the emit step and drives the outputs
//   from the cycle after.
// Reset: control state and hashes clear at once; both RAMs are left as they are
//   and only entries written since are ever read. No clearing pass.
// Stall: a result waits in the output register; the next transaction is still
//   taken, and the block only holds in its emit step if a second result is due.
`include "rolling_hash_string_matcher_unit_assert.svh"

module rolling_hash_string_matcher_unit #(
    parameter int MAX_PATTERN   = rhsm_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = rhsm_pkg::POSITION_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [1:0]                  opcode,
    input  logic [7:0]                  char_byte,
    input  logic                        end_of_text,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [1:0]                  status,
    output logic [POSITION_BITS-1:0]    position,
    output logic [rhsm_pkg::HASH_W-1:0] window_hash
);
    import rhsm_pkg::*;

    localparam int               AW      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int               LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_LOAD    = 6'b000010,
        S_WAIT    = 6'b000100,
        S_CMP_RD  = 6'b001000,
        S_CMP_CHK = 6'b010000,
        S_EMIT    = 6'b100000
    } state_t;

    // what the pending reducer pass computes
    typedef enum logic [1:0] {
        PH_PAT_HASH = 2'd0,
        PH_PAT_POW  = 2'd1,
        PH_TEXT_SUB = 2'd2,
        PH_TEXT_ADD = 2'd3
    } phase_t;

    state_t                   state_reg, state_next;
    phase_t                   phase_reg, phase_next;
    logic [LEN_W-1:0]         pat_len_reg, pat_len_next;
    logic [HASH_W-1:0]        pat_hash_reg, pat_hash_next;
    logic [HASH_W-1:0]        lead_pow_reg, lead_pow_next;
    logic [HASH_W-1:0]        roll_hash_reg, roll_hash_next;
    logic [TEXT_COUNT_W-1:0]  text_count_reg, text_count_next;
    logic [AW-1:0]            ring_head_reg, ring_head_next;
    logic [7:0]               char_reg, char_next;
    logic                     last_reg, last_next;
    logic                     pow_pending_reg, pow_pending_next;
    logic [AW-1:0]            cmp_j_reg, cmp_j_next;
    logic [AW-1:0]            cmp_k_reg, cmp_k_next;
    status_t                  res_status_reg, res_status_next;
    logic [POSITION_BITS-1:0] res_pos_reg, res_pos_next;
    logic [HASH_W-1:0]        res_hash_reg, res_hash_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg;
    logic [POSITION_BITS-1:0] out_pos_reg;
    logic [HASH_W-1:0]        out_hash_reg;

    logic                     accept;
    logic                     out_load;
    opcode_t                  op;
    logic                     pat_empty;
    logic [TEXT_COUNT_W-1:0]  pat_len_wide;
    logic                     window_full;
    logic [TEXT_COUNT_W-1:0]  text_count_inc;
    logic [AW-1:0]            head_adv;
    logic [AW-1:0]            k_adv;
    logic                     last_cmp;
    logic [TEXT_COUNT_W-1:0]  pos_diff;
    logic [POSITION_BITS+TEXT_COUNT_W-1:0] pos_diff_ext;
    logic [POSITION_BITS+TEXT_COUNT_W-1:0] pos_count_ext;
    logic [7:0]               sub_sum;
    logic [HASH_W-1:0]        sub_mod;

    // memories
    logic                     pat_we;
    logic                     ring_we;
    logic [AW-1:0]            ring_waddr;
    logic [AW-1:0]            ring_raddr;
    logic [7:0]               pat_rdata;
    logic [7:0]               ring_rdata;

    // reducer
    logic                     red_start;
    logic [RED_W-1:0]         red_operand;
    logic                     red_done;
    logic [HASH_W-1:0]        red_residue;

    rhsm_ram #(
        .WIDTH  (8),
        .DEPTH  (MAX_PATTERN),
        .ADDR_W (AW)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_len_reg[AW-1:0]),
        .wdata (char_byte),
        .raddr (cmp_j_reg),
        .rdata (pat_rdata)
    );

    rhsm_ram #(
        .WIDTH  (8),
        .DEPTH  (MAX_PATTERN),
        .ADDR_W (AW)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (char_byte),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    rhsm_mod101 u_mod101 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .operand (red_operand),
        .done    (red_done),
        .residue (red_residue)
    );

    // handshake
    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign position     = out_pos_reg;
    assign window_hash  = out_hash_reg;

    assign op           = opcode_t'(opcode);
    assign pat_empty    = (pat_len_reg == '0);
    assign pat_len_wide = {{(TEXT_COUNT_W-LEN_W){1'b0}}, pat_len_reg};
    assign window_full  = (text_count_reg >= pat_len_wide);
    assign text_count_inc = (text_count_reg == TEXT_COUNT_MAX) ? text_count_reg
                                                               : text_count_reg + 1'b1;

    // ring index wraps at the pattern length, not at the RAM depth
    assign head_adv = ((LEN_W'(ring_head_reg) + 1'b1) == pat_len_reg) ? '0
                                                                     : ring_head_reg + 1'b1;
    assign k_adv    = ((LEN_W'(cmp_k_reg) + 1'b1) == pat_len_reg) ? '0 : cmp_k_reg + 1'b1;
    assign last_cmp = ((LEN_W'(cmp_j_reg) + 1'b1) == pat_len_reg);

    // window start index, zero-extended or cut to POSITION_BITS
    assign pos_diff      = text_count_reg - pat_len_wide;
    assign pos_diff_ext  = {{POSITION_BITS{1'b0}}, pos_diff};
    assign pos_count_ext = {{POSITION_BITS{1'b0}}, text_count_reg};

    // (h + 101 - old*lead mod 101) mod 101; sum is at most 201
    assign sub_sum = {1'b0, roll_hash_reg} + {1'b0, MODULUS} - {1'b0, red_residue};
    assign sub_mod = (sub_sum >= {1'b0, MODULUS}) ? HASH_W'(sub_sum - {1'b0, MODULUS})
                                                   : sub_sum[HASH_W-1:0];

    assign ring_raddr = (state_reg == S_CMP_RD) ? cmp_k_reg : ring_head_reg;
    assign out_load   = (state_reg == S_EMIT) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        pat_len_next     = pat_len_reg;
        pat_hash_next    = pat_hash_reg;
        lead_pow_next    = lead_pow_reg;
        roll_hash_next   = roll_hash_reg;
        text_count_next  = text_count_reg;
        ring_head_next   = ring_head_reg;
        char_next        = char_reg;
        last_next        = last_reg;
        pow_pending_next = pow_pending_reg;
        cmp_j_next       = cmp_j_reg;
        cmp_k_next       = cmp_k_reg;
        res_status_next  = res_status_reg;
        res_pos_next     = res_pos_reg;
        res_hash_next    = res_hash_reg;
        pat_we           = 1'b0;
        ring_we          = 1'b0;
        ring_waddr       = ring_head_reg;
        red_start        = 1'b0;
        red_operand      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_CLEAR:
                        begin
                            pat_len_next    = '0;
                            pat_hash_next   = '0;
                            lead_pow_next   = LEAD_ONE;
                            text_count_next = '0;
                            roll_hash_next  = '0;
                            ring_head_next  = '0;
                        end
                        OP_RESTART:
                        begin
                            text_count_next = '0;
                            roll_hash_next  = '0;
                            ring_head_next  = '0;
                        end
                        OP_PATTERN:
                        begin
                            text_count_next = '0;
                            roll_hash_next  = '0;
                            ring_head_next  = '0;
                            // bytes past the store size are dropped
                            if (pat_len_reg < LEN_MAX)
                            begin
                                pat_we           = 1'b1;
                                pat_len_next     = pat_len_reg + 1'b1;
                                pow_pending_next = !pat_empty;
                                red_start        = 1'b1;
                                red_operand      = RED_W'(pat_hash_reg) * RED_W'(RADIX_MOD)
                                                 + RED_W'(char_byte);
                                phase_next       = PH_PAT_HASH;
                                state_next       = S_WAIT;
                            end
                        end
                        OP_TEXT:
                        begin
                            char_next       = char_byte;
                            last_next       = end_of_text;
                            text_count_next = text_count_inc;
                            if (pat_empty)
                            begin
                                // empty pattern matches everywhere
                                res_status_next = ST_FOUND;
                                res_pos_next    = pos_count_ext[POSITION_BITS-1:0];
                                res_hash_next   = '0;
                                state_next      = S_EMIT;
                            end
                            else if (window_full)
                            begin
                                // read-first RAM returns the byte leaving the window
                                ring_we        = 1'b1;
                                ring_waddr     = ring_head_reg;
                                ring_head_next = head_adv;
                                state_next     = S_LOAD;
                            end
                            else
                            begin
                                ring_we     = 1'b1;
                                ring_waddr  = text_count_reg[AW-1:0];
                                red_start   = 1'b1;
                                red_operand = RED_W'(roll_hash_reg) * RED_W'(RADIX_MOD)
                                            + RED_W'(char_byte);
                                phase_next  = PH_TEXT_ADD;
                                state_next  = S_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                red_start   = 1'b1;
                red_operand = RED_W'(ring_rdata) * RED_W'(lead_pow_reg);
                phase_next  = PH_TEXT_SUB;
                state_next  = S_WAIT;
            end

            S_WAIT:
            begin
                if (red_done)
                begin
                    case (phase_reg)
                        PH_PAT_HASH:
                        begin
                            pat_hash_next = red_residue;
                            if (pow_pending_reg)
                            begin
                                red_start   = 1'b1;
                                red_operand = RED_W'(lead_pow_reg) * RED_W'(RADIX_MOD);
                                phase_next  = PH_PAT_POW;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        PH_PAT_POW:
                        begin
                            lead_pow_next = red_residue;
                            state_next    = S_IDLE;
                        end
                        PH_TEXT_SUB:
                        begin
                            red_start   = 1'b1;
                            red_operand = RED_W'(sub_mod) * RED_W'(RADIX_MOD)
                                        + RED_W'(char_reg);
                            phase_next  = PH_TEXT_ADD;
                        end
                        default:
                        begin
                            roll_hash_next = red_residue;
                            res_pos_next   = pos_diff_ext[POSITION_BITS-1:0];
                            res_hash_next  = red_residue;
                            if (text_count_reg < pat_len_wide)
                            begin
                                // window still filling: result only if text ends
                                if (last_reg)
                                begin
                                    res_status_next = ST_SHORT_TEXT;
                                    res_pos_next    = '0;
                                    res_hash_next   = '0;
                                    state_next      = S_EMIT;
                                end
                                else
                                begin
                                    state_next = S_IDLE;
                                end
                            end
                            else if (red_residue == pat_hash_reg)
                            begin
                                cmp_j_next = '0;
                                cmp_k_next = ring_head_reg;
                                state_next = S_CMP_RD;
                            end
                            else
                            begin
                                res_status_next = ST_NO_MATCH;
                                state_next      = S_EMIT;
                            end
                        end
                    endcase
                end
            end

            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end

            S_CMP_CHK:
            begin
                if (ring_rdata != pat_rdata)
                begin
                    res_status_next = ST_FALSE_HIT;
                    state_next      = S_EMIT;
                end
                else if (last_cmp)
                begin
                    res_status_next = ST_FOUND;
                    state_next      = S_EMIT;
                end
                else
                begin
                    cmp_j_next = cmp_j_reg + 1'b1;
                    cmp_k_next = k_adv;
                    state_next = S_CMP_RD;
                end
            end

            S_EMIT:
            begin
                if (out_load)
                begin
                    // end of text: next text byte starts at index 0
                    if (last_reg)
                    begin
                        text_count_next = '0;
                        roll_hash_next  = '0;
                        ring_head_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_PAT_HASH;
            pat_len_reg     <= '0;
            pat_hash_reg    <= '0;
            lead_pow_reg    <= LEAD_ONE;
            roll_hash_reg   <= '0;
            text_count_reg  <= '0;
            ring_head_reg   <= '0;
            last_reg        <= 1'b0;
            pow_pending_reg <= 1'b0;
            cmp_j_reg       <= '0;
            cmp_k_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            pat_len_reg     <= pat_len_next;
            pat_hash_reg    <= pat_hash_next;
            lead_pow_reg    <= lead_pow_next;
            roll_hash_reg   <= roll_hash_next;
            text_count_reg  <= text_count_next;
            ring_head_reg   <= ring_head_next;
            last_reg        <= last_next;
            pow_pending_reg <= pow_pending_next;
            cmp_j_reg       <= cmp_j_next;
            cmp_k_reg       <= cmp_k_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_hash_reg   <= res_hash_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= res_pos_reg;
            out_hash_reg   <= res_hash_reg;
        end
    end

    `RHSM_ASSERT_IMPL(a_hash_range, 1'b1,
        (roll_hash_reg < MODULUS) && (pat_hash_reg < MODULUS) && (lead_pow_reg < MODULUS),
        "hash register out of range")
    `RHSM_ASSERT_IMPL(a_head_in_window, !pat_empty,
        (LEN_W'(ring_head_reg) < pat_len_reg), "ring head beyond pattern length")
    `RHSM_ASSERT_IMPL(a_done_in_wait, red_done, (state_reg == S_WAIT),
        "reducer finished outside wait step")
    `RHSM_ASSERT_IMPL(a_cmp_bounds, (state_reg == S_CMP_RD),
        (LEN_W'(cmp_j_reg) < pat_len_reg) && (LEN_W'(cmp_k_reg) < pat_len_reg),
        "compare walk index out of range")
    `RHSM_ASSERT_NEXT(a_emit_holds, (state_reg == S_EMIT) && out_valid_reg && result_stall,
        (state_reg == S_EMIT), "result dropped while output register busy")

endmodule

// ===== rtl/core/rhsm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. No package dependency.
module rhsm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rhsm_mod101.sv =====
// Mod-101 reducer shared by every hash update: a quotient stage, then a remainder stage.
// Depends on rhsm_pkg and rolling_hash_string_matcher_unit_assert.svh.
`include "rolling_hash_string_matcher_unit_assert.svh"

module rhsm_mod101 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rhsm_pkg::RED_W-1:0]  operand,
    output logic                        done,
    output logic [rhsm_pkg::HASH_W-1:0] residue
);
    import rhsm_pkg::*;

    logic [RED_W-1:0]         x_reg;
    logic [QUOT_W-1:0]        q_reg;
    logic                     stage1_reg;
    logic                     stage2_reg;
    logic [RED_W+RECIP_W-1:0] recip_prod;
    logic [RED_W-1:0]         q_times_mod;
    logic [RED_W-1:0]         diff;

    // quotient by reciprocal multiply
    assign recip_prod  = {{RECIP_W{1'b0}}, x_reg} * {{RED_W{1'b0}}, RECIP};
    // remainder from the registered quotient
    assign q_times_mod = RED_W'(q_reg) * RED_W'(MODULUS);
    assign diff        = x_reg - q_times_mod;
    assign residue     = diff[HASH_W-1:0];
    assign done        = stage2_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= operand;
        end
        q_reg <= recip_prod[RECIP_SHIFT +: QUOT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            stage2_reg <= stage1_reg;
        end
    end

    `RHSM_ASSERT_IMPL(a_red_range, done, residue < MODULUS, "mod101 residue out of range")
    `RHSM_ASSERT_IMPL(a_red_latency, done, $past(start, 2), "mod101 done without start")
    `RHSM_ASSERT_NEXT(a_red_no_overlap, start, !start, "mod101 restarted while busy")

endmodule

// ===== tb/sv/rolling_hash_string_matcher_unit_tb.sv =====
// Self-checking testbench for the rolling hash string matcher.
// Needs rhsm_pkg and the rolling_hash_string_matcher_unit RTL; reads no files.
`timescale 1ns / 1ps

module rolling_hash_string_matcher_unit_tb;

    import rhsm_pkg::*;

    localparam int MAX_PAT    = MAX_PATTERN_DEF;
    localparam int POS_W      = POSITION_BITS_DEF;
    localparam int RAND_ITEMS = 1250;
    // One unbroken text with an empty pattern and no idling.
    localparam int LONG_TEXT  = 150;
    localparam int TAIL_WAIT  = 200;

    typedef struct {
        status_t              st;
        logic [POS_W-1:0]     pos;
        logic [HASH_W-1:0]    hash;
    } match_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic [1:0]           opcode;
    logic [7:0]           char_byte;
    logic                 end_of_text;
    logic                 result_valid;
    logic                 result_stall;
    logic [1:0]           status;
    logic [POS_W-1:0]     position;
    logic [HASH_W-1:0]    window_hash;

    rolling_hash_string_matcher_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .char_byte    (char_byte),
        .end_of_text  (end_of_text),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .position     (position),
        .window_hash  (window_hash)
    );

    // ------------------------------------------------------------------
    // Matcher model state: pattern bytes, text window ring, both hashes.
    // ------------------------------------------------------------------
    logic [7:0]    pat_mem [MAX_PAT];
    logic [7:0]    win_mem [MAX_PAT];
    int unsigned   pat_len;
    int unsigned   pat_sig;
    int unsigned   lead_weight;   // 256^(m-1) mod 101
    int unsigned   win_sig;
    int unsigned   txt_count;     // saturates at TEXT_COUNT_MAX
    int unsigned   win_head;      // oldest byte once the window is full

    match_result_t expected_matches[$];

    // Test control shared by the stimulus, the result receiver and the checker.
    int            failures = 0;
    int            items_sent = 0;
    bit            tx_idle_on = 0;
    bit            rx_idle_on = 0;
    int            rx_hold_left = 0;

    // Pattern the random generator currently builds text around.
    logic [7:0]    cur_pat [72];
    int            cur_len = 0;

    function automatic void restart_window();
        txt_count = 0;
        win_sig   = 0;
        win_head  = 0;
    endfunction

    function automatic void clear_matcher();
        pat_len     = 0;
        pat_sig     = 0;
        lead_weight = 1;
        restart_window();
    endfunction

    // Walk the ring from its oldest byte against the pattern.
    function automatic bit window_is_pattern();
        int unsigned k;
        int unsigned j;
        k = win_head;
        for (j = 0; j < pat_len; j++) begin
            if (win_mem[k] != pat_mem[j])
                return 1'b0;
            k = (k + 1 == pat_len) ? 0 : k + 1;
        end
        return 1'b1;
    endfunction

    function automatic void bump_count();
        if (txt_count < TEXT_COUNT_MAX)
            txt_count++;
    endfunction

    // Advance the model by one accepted transaction; queue the result it causes.
    function automatic void predict_match(opcode_t op, logic [7:0] ch, logic eot);
        int unsigned   m;
        int unsigned   fill;
        int unsigned   drop;
        match_result_t r;
        m = pat_len;
        case (op)
            OP_CLEAR:   clear_matcher();
            OP_RESTART: restart_window();
            OP_PATTERN:
            begin
                restart_window();
                // bytes past the store depth are dropped
                if (m < MAX_PAT)
                begin
                    pat_mem[m] = ch;
                    pat_sig    = (pat_sig * 256 + ch) % 101;
                    if (m >= 1)
                        lead_weight = (lead_weight * 256) % 101;
                    pat_len = m + 1;
                end
            end
            OP_TEXT:
            begin
                if (m == 0)
                begin
                    // empty pattern: every byte is a find at its own index
                    r.st   = ST_FOUND;
                    r.pos  = POS_W'(txt_count);
                    r.hash = '0;
                    expected_matches.push_back(r);
                    bump_count();
                    if (eot)
                        restart_window();
                end
                else
                begin
                    fill = (txt_count < m) ? txt_count : m;
                    if (fill < m)
                    begin
                        win_mem[fill] = ch;
                        win_sig = (win_sig * 256 + ch) % 101;
                    end
                    else
                    begin
                        drop    = (win_mem[win_head] * lead_weight) % 101;
                        win_sig = (((win_sig + 101 - drop) % 101) * 256 + ch) % 101;
                        win_mem[win_head] = ch;
                        win_head = (win_head + 1 == m) ? 0 : win_head + 1;
                    end
                    bump_count();
                    if (txt_count < m)
                    begin
                        // text ended before the window filled
                        if (eot)
                        begin
                            r.st   = ST_SHORT_TEXT;
                            r.pos  = '0;
                            r.hash = '0;
                            expected_matches.push_back(r);
                            restart_window();
                        end
                    end
                    else
                    begin
                        if (win_sig == pat_sig)
                            r.st = window_is_pattern() ? ST_FOUND : ST_FALSE_HIT;
                        else
                            r.st = ST_NO_MATCH;
                        r.pos  = POS_W'(txt_count - m);
                        r.hash = HASH_W'(win_sig);
                        expected_matches.push_back(r);
                        if (eot)
                            restart_window();
                    end
                end
            end
        endcase
    endfunction

    // Byte with the same residue mod 101, different value: forces a false hit.
    function automatic logic [7:0] alias_of(logic [7:0] c);
        return (c >= 8'd101) ? c - 8'd101 : c + 8'd101;
    endfunction

    function automatic logic [7:0] text_byte(int plen);
        int pick;
        if (plen == 0)
            return 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return cur_pat[$urandom_range(0, plen - 1)];
        if (pick < 7)
            return alias_of(cur_pat[$urandom_range(0, plen - 1)]);
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Ends the run as a failure if the sequence hangs.
    initial
    begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: one transaction per call. Drives at the falling edge and
    // predicts at the rising edge where the block takes it.
    // ------------------------------------------------------------------
    task automatic send_item(input opcode_t op, input logic [7:0] ch, input logic eot);
        int gap;
        @(negedge clk);
        if (tx_idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid  <= 1'b1;
        opcode      <= op;
        char_byte   <= ch;
        end_of_text <= eot;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        // dropped pattern bytes do nothing, so they are not counted
        if (!(op == OP_PATTERN && pat_len >= MAX_PAT))
            items_sent++;
        predict_match(op, ch, eot);
    endtask

    // Drop valid and hold until every queued result has been checked.
    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
    endtask

    // Clear, then load a fresh pattern of len bytes (extra bytes past the store get dropped).
    task automatic load_pattern(input int len);
        int i;
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        for (i = 0; i < len; i++)
        begin
            cur_pat[i] = 8'($urandom_range(0, 255));
            send_item(OP_PATTERN, cur_pat[i], 1'($urandom_range(0, 1)));
        end
        cur_len = len;
    endtask

    // Text built from units: either a whole pattern copy (sometimes with one
    // byte swapped for its alias) or a single byte biased toward pattern bytes.
    task automatic send_text_run(input int units, input bit close_eot);
        int         plen;
        int         alias_at;
        int         u;
        int         j;
        bit         last_unit;
        logic [7:0] b;
        plen = (cur_len < MAX_PAT) ? cur_len : MAX_PAT;
        for (u = 0; u < units; u++)
        begin
            last_unit = (u == units - 1);
            if (plen > 0 && $urandom_range(0, 3) == 0)
            begin
                alias_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, plen - 1) : -1;
                for (j = 0; j < plen; j++)
                begin
                    b = cur_pat[j];
                    if (j == alias_at)
                        b = alias_of(b);
                    send_item(OP_TEXT, b, close_eot && last_unit && j == plen - 1);
                end
            end
            else
                send_item(OP_TEXT, text_byte(plen), close_eot && last_unit);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked transactions: empty pattern, byte extremes, ignored
    // end_of_text, true and false hits, short text, restart and clear.
    task automatic test_directed();
        tx_idle_on = 0;
        rx_idle_on = 0;
        send_item(OP_TEXT, 8'h00, 1'b0);       // empty pattern: found at 0
        send_item(OP_TEXT, 8'hFF, 1'b1);       // found at 1, text restarts
        send_item(OP_TEXT, 8'h41, 1'b0);       // new text, found at 0
        send_item(OP_RESTART, 8'hFF, 1'b1);    // end_of_text ignored here
        send_item(OP_CLEAR, 8'hFF, 1'b1);
        send_item(OP_PATTERN, 8'h05, 1'b1);    // one-byte pattern, hash 5
        send_item(OP_TEXT, 8'h05, 1'b0);       // found
        send_item(OP_TEXT, 8'h6A, 1'b0);       // 106 = 5 mod 101: false hit
        send_item(OP_TEXT, 8'h07, 1'b0);       // no match
        send_item(OP_TEXT, 8'hCA, 1'b1);       // no match, text ends
        send_item(OP_PATTERN, 8'hFF, 1'b0);    // pattern 05 FF
        send_item(OP_TEXT, 8'h05, 1'b1);       // text shorter than pattern
        send_item(OP_TEXT, 8'h05, 1'b0);
        send_item(OP_TEXT, 8'hFF, 1'b0);       // found at 0
        send_item(OP_TEXT, 8'h05, 1'b0);       // no match
        send_item(OP_TEXT, 8'hFF, 1'b0);       // found at 2
        send_item(OP_RESTART, 8'h00, 1'b0);
        send_item(OP_TEXT, 8'h6A, 1'b0);
        send_item(OP_TEXT, 8'hFF, 1'b1);       // false hit at 0
        send_item(OP_CLEAR, 8'h00, 1'b0);
        send_item(OP_TEXT, 8'h00, 1'b1);       // empty again after clear
    endtask

    // Pattern longer than the store: the tail is dropped and a full-depth
    // copy in the text takes the longest compare walk.
    task automatic test_pattern_overflow();
        int i;
        tx_idle_on = 1;
        rx_idle_on = 1;
        load_pattern(MAX_PAT + 6);
        for (i = 0; i < 3; i++)
            send_item(OP_TEXT, 8'($urandom_range(0, 255)), 1'b0);
        for (i = 0; i < MAX_PAT; i++)
            send_item(OP_TEXT, cur_pat[i], i == MAX_PAT - 1);
    endtask

    // Receiver holds off long enough for the block to back up and stall
    // its input while the sender keeps offering; then the sender pauses
    // until everything has drained, then sends one more text run that ends the text.
    task automatic test_backpressure();
        int i;
        tx_idle_on = 0;
        rx_idle_on = 0;
        load_pattern(2);
        rx_hold_left = 400;
        for (i = 0; i < 40; i++)
            send_item(OP_TEXT, text_byte(2), 1'b0);
        wait_drained();
        send_text_run(10, 1'b1);
    endtask

    // Mostly well-formed pattern/text sequences with random content, plus
    // some raw noise. Idling comes and goes by segment, none at the end.
    task automatic test_random_traffic();
        int goal;
        int kind;
        int len;
        int i;
        bit tail;
        goal = items_sent + RAND_ITEMS;
        while (items_sent < goal)
        begin
            tail       = (goal - items_sent) < RAND_ITEMS / 5;
            tx_idle_on = !tail && $urandom_range(0, 3) != 0;
            rx_idle_on = !tail && $urandom_range(0, 3) != 0;
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                for (i = 0; i < 8; i++)
                    send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
            else
            begin
                if (kind <= 6)
                begin
                    case ($urandom_range(0, 19))
                        0:       len = 0;
                        1:       len = $urandom_range(MAX_PAT - 4, MAX_PAT + 6);
                        2, 3, 4: len = $urandom_range(5, 12);
                        default: len = $urandom_range(1, 4);
                    endcase
                    load_pattern(len);
                end
                else
                    send_item(OP_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                send_text_run($urandom_range(1, 12), $urandom_range(0, 3) != 0);
            end
        end
    endtask

    // Empty pattern, one long text sent back to back with no idling:
    // position counts up byte by byte.
    task automatic test_long_text();
        int i;
        tx_idle_on = 0;
        rx_idle_on = 0;
        send_item(OP_CLEAR, 8'h00, 1'b0);
        for (i = 0; i < LONG_TEXT; i++)
            send_item(OP_TEXT, 8'($urandom_range(0, 255)), i == LONG_TEXT - 1);
    endtask

    // ------------------------------------------------------------------
    // Result receiver: a long hold when one is asked for, else random stall bursts while idling is on.
    // ------------------------------------------------------------------
    initial
    begin
        int burst;
        result_stall = 1'b0;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                result_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 15);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    initial
    begin
        match_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (expected_matches.size() == 0)
                begin
                    $error("unexpected result: status=%0d position=%0d window_hash=%0d",
                           status, position, window_hash);
                    failures++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, actual %0d", want.st, status);
                        failures++;
                    end
                    if (position !== want.pos)
                    begin
                        $error("position: expected %0d, actual %0d", want.pos, position);
                        failures++;
                    end
                    if (window_hash !== want.hash)
                    begin
                        $error("window_hash: expected %0d, actual %0d", want.hash, window_hash);
                        failures++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        opcode      = OP_CLEAR;
        char_byte   = 8'h00;
        end_of_text = 1'b0;
        clear_matcher();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_pattern_overflow();
        test_backpressure();
        test_random_traffic();
        test_long_text();

        wait_drained();
        // let any trailing compare walk finish so a stray result is caught
        repeat (TAIL_WAIT) @(posedge clk);
        if (failures == 0 && expected_matches.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
